[sv/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// No dependencies; included by every module that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property at each rising edge, ignored while reset is asserted.
`define ASSERT_ON(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check a property at each rising edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_ON(name, clk, rst_n, prop)
`define ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

[sv/frha_pkg.sv]
// Types, constants and sizes for the FIFO-reuse handle allocator.
// No dependencies; imported by every allocator module.
package frha_pkg;

    localparam int POOL_SIZE = 64;
    localparam int HANDLE_W  = 6;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    // Queue pointer / handle index width and the matching count width.
    localparam int PTR_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W = PTR_W + 1;
    // Wide enough to compare a request handle against the pool size.
    localparam int REQ_W = ((PTR_W > HANDLE_W) ? PTR_W : HANDLE_W) + 1;

    typedef logic [PTR_W-1:0] t_hidx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_TRY   = 2'd1,
        MODE_FREE  = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREED  = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_BAD_FREE  = 2'd3
    } t_status;

    // Requests from the core to the free queue.
    typedef struct packed {
        logic  push;
        logic  pop;
        t_hidx push_data;
    } t_q_ctl;

    // Free queue state seen by the core.
    typedef struct packed {
        logic  nonempty;
        logic  full;
        t_hidx head_data;
    } t_q_stat;

    // Single write into the held map.
    typedef struct packed {
        logic  wr_en;
        logic  wr_val;
        t_hidx wr_idx;
    } t_map_ctl;

endpackage

[sv/frha_free_queue.sv]
// Circular queue of freed handles with a prefetched head entry.
// Depends on frha_pkg and assert_macros.svh.
`include "assert_macros.svh"

module frha_free_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  frha_pkg::t_q_ctl i_ctl,
    output frha_pkg::t_q_stat o_stat
);
    import frha_pkg::*;

    t_hidx r_mem [POOL_SIZE];
    t_hidx r_head;
    t_hidx r_tail;
    t_cnt  r_count;
    t_hidx r_rd;

    t_hidx n_head;
    t_hidx n_tail;
    t_cnt  n_count;

    function automatic t_hidx wrap_next(input t_hidx ptr);
        t_hidx res;
        if (ptr == PTR_W'(POOL_SIZE - 1)) begin
            res = '0;
        end else begin
            res = ptr + 1'b1;
        end
        return res;
    endfunction

    always_comb begin
        n_head  = i_ctl.pop  ? wrap_next(r_head) : r_head;
        n_tail  = i_ctl.push ? wrap_next(r_tail) : r_tail;
        n_count = r_count;
        if (i_ctl.push && !i_ctl.pop) begin
            n_count = r_count + 1'b1;
        end else if (i_ctl.pop && !i_ctl.push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_tail] <= i_ctl.push_data;
        end
    end

    // Keep the entry at the head ready; forward a write landing on it.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push && (r_tail == n_head)) begin
            r_rd <= i_ctl.push_data;
        end else begin
            r_rd <= r_mem[n_head];
        end
    end

    assign o_stat.nonempty  = (r_count != '0);
    assign o_stat.full      = (r_count == CNT_W'(POOL_SIZE));
    assign o_stat.head_data = r_rd;

    `ASSERT_ON(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(POOL_SIZE))
    `ASSERT_ON(a_no_pop_empty, i_clk, i_rst_n, i_ctl.pop |-> r_count != '0)
    `ASSERT_ON(a_no_push_full, i_clk, i_rst_n, i_ctl.push |-> r_count != CNT_W'(POOL_SIZE))
    `ASSERT_ON(a_one_op, i_clk, i_rst_n, !(i_ctl.push && i_ctl.pop))
    `ASSERT_ON(a_empty_ptrs, i_clk, i_rst_n, r_count == '0 |-> r_head == r_tail)

endmodule

[sv/frha_held_map.sv]
// One flag per handle, set while the handle is out with a client.
// Depends on frha_pkg and assert_macros.svh.
`include "assert_macros.svh"

module frha_held_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  frha_pkg::t_hidx    i_rd_idx,
    input  frha_pkg::t_map_ctl i_ctl,
    output logic               o_rd_held
);
    import frha_pkg::*;

    logic [POOL_SIZE-1:0] r_map;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_ctl.wr_en) begin
            r_map[i_ctl.wr_idx] <= i_ctl.wr_val;
        end
    end

    assign o_rd_held = r_map[i_rd_idx];

    `ASSERT_ON(a_set_unheld, i_clk, i_rst_n, i_ctl.wr_en && i_ctl.wr_val |-> !r_map[i_ctl.wr_idx])
    `ASSERT_ON(a_clr_held, i_clk, i_rst_n, i_ctl.wr_en && !i_ctl.wr_val |-> r_map[i_ctl.wr_idx])
    `ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> r_map == '0)

endmodule

[sv/fifo_reuse_handle_allocator.sv]
// Top level of the FIFO-reuse handle allocator: request register, decision logic,
// fresh-handle counter and result register. Depends on frha_pkg, frha_free_queue,
// frha_held_map and assert_macros.svh.
//
//   channel   direction   handshake             payload
//   request   in          i_valid / o_stall     i_mode, i_handle
//   result    out         o_valid / i_stall     o_granted_handle, o_status
//
// One request per cycle while o_stall is low; a result passes the request register,
// then the result register, with a single combinational pass through the held-map
// lookup, free-queue head and fresh counter between those registers.
// Reset clears the held map, queue pointers and fresh counter.
// A stalled result holds the result register and, once the request register is
// full behind it, o_stall rises.
`include "assert_macros.svh"

module fifo_reuse_handle_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [frha_pkg::MODE_W-1:0]   i_mode,
    input  logic [frha_pkg::HANDLE_W-1:0] i_handle,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [frha_pkg::HANDLE_W-1:0] o_granted_handle,
    output logic [frha_pkg::STATUS_W-1:0] o_status
);
    import frha_pkg::*;

    logic                r_in_valid;
    t_mode               r_in_mode;
    logic [HANDLE_W-1:0] r_in_handle;
    logic                r_out_valid;
    logic [HANDLE_W-1:0] r_out_handle;
    t_status             r_out_status;
    t_cnt                r_fresh;

    t_cnt                n_fresh;
    logic [HANDLE_W-1:0] n_out_handle;
    t_status             n_out_status;

    logic       adv;
    logic       fire;
    logic [REQ_W-1:0] req_ext;
    logic       req_in_range;
    t_hidx      req_idx;
    logic       req_held;
    t_q_ctl     q_ctl;
    t_q_stat    q_stat;
    t_map_ctl   map_ctl;

    assign adv     = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && adv;
    assign o_stall = r_in_valid && !adv;

    assign req_ext      = REQ_W'(r_in_handle);
    assign req_in_range = (req_ext < REQ_W'(POOL_SIZE));
    assign req_idx      = req_ext[PTR_W-1:0];

    frha_free_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .o_stat  (q_stat)
    );

    frha_held_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_idx  (req_idx),
        .i_ctl     (map_ctl),
        .o_rd_held (req_held)
    );

    always_comb begin
        n_fresh      = r_fresh;
        n_out_handle = '0;
        n_out_status = ST_OK;
        q_ctl        = '0;
        map_ctl      = '0;
        case (r_in_mode)
            MODE_ALLOC, MODE_TRY: begin
                if (q_stat.nonempty) begin
                    // Reuse the oldest freed handle.
                    q_ctl.pop      = fire;
                    map_ctl.wr_en  = fire;
                    map_ctl.wr_val = 1'b1;
                    map_ctl.wr_idx = q_stat.head_data;
                    n_out_handle   = HANDLE_W'(q_stat.head_data);
                end else if (r_in_mode == MODE_TRY) begin
                    n_out_status = ST_NO_FREED;
                end else if (r_fresh < CNT_W'(POOL_SIZE)) begin
                    map_ctl.wr_en  = fire;
                    map_ctl.wr_val = 1'b1;
                    map_ctl.wr_idx = r_fresh[PTR_W-1:0];
                    n_out_handle   = HANDLE_W'(r_fresh[PTR_W-1:0]);
                    if (fire) begin
                        n_fresh = r_fresh + 1'b1;
                    end
                end else begin
                    n_out_status = ST_EXHAUSTED;
                end
            end
            MODE_FREE: begin
                if (req_in_range && req_held && !q_stat.full) begin
                    map_ctl.wr_en   = fire;
                    map_ctl.wr_val  = 1'b0;
                    map_ctl.wr_idx  = req_idx;
                    q_ctl.push      = fire;
                    q_ctl.push_data = req_idx;
                end else begin
                    n_out_status = ST_BAD_FREE;
                end
            end
            default: begin
                n_out_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fresh     <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            r_fresh <= n_fresh;
        end
    end

    // Payload registers: load on a taken request, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_mode   <= t_mode'(i_mode);
            r_in_handle <= i_handle;
        end
        if (fire) begin
            r_out_handle <= n_out_handle;
            r_out_status <= n_out_status;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_granted_handle = r_out_handle;
    assign o_status         = r_out_status;

    `ASSERT_ON(a_fail_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK |-> o_granted_handle == '0)
    `ASSERT_ON(a_fresh_bound, i_clk, i_rst_n, r_fresh <= CNT_W'(POOL_SIZE))
    `ASSERT_ON(a_ready_when_empty, i_clk, i_rst_n, !r_out_valid |-> !o_stall)
    `ASSERT_ON(a_state_quiet, i_clk, i_rst_n, !fire |=> r_fresh == $past(r_fresh))

endmodule
